FILE: hdl/erct_pkg.sv
// Shared types and constants for the M/M/c response time block.
`timescale 1ns / 1ps
package erct_pkg;

    localparam int MAX_SERVERS    = 64;
    localparam int PROB_FRAC_BITS = 30;
    localparam int CNT_W          = 7;                 // cpu_count register width
    localparam int UTIL_W         = 16;
    localparam int SVC_W          = 32;
    localparam int RESP_W         = 48;
    localparam int PROB_W         = PROB_FRAC_BITS + 1;
    localparam int LOAD_W         = CNT_W + UTIL_W;    // offered load a = c*u, Q.16
    localparam int DEN_W          = 40;                // divisor width
    localparam int WORD_W         = 64;                // dividend shift word
    localparam int STEP_W         = 7;                 // divider step count
    localparam int MUL_W          = 32;
    localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1) << PROB_FRAC_BITS;

    typedef enum logic [1:0] {
        MS_AB  = 2'd0,   // a * B
        MS_UOB = 2'd1,   // u * (1 - B)
        MS_CS  = 2'd2    // C * s
    } mul_sel_t;

    typedef enum logic [1:0] {
        DS_ONE = 2'd0,   // one-server quotient
        DS_B   = 2'd1,   // Erlang B step
        DS_C   = 2'd2,   // Erlang C step
        DS_F   = 2'd3    // waiting-time term
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_go;
        mul_sel_t mul_sel;
        logic     div_go;
        div_sel_t div_sel;
        logic     b_upd;
        logic     c_upd;
        logic     res_upd;
        logic     res_fin;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic single;
        logic k_last;
    } dp_stat_t;

endpackage

FILE: hdl/erlang_c_response_time.sv
// Top level: M/M/c mean response time with APB configuration.
//
//  channel  | ports                          | moves
//  ---------+--------------------------------+-------------------------------
//  input    | s_valid s_ready s_service_time | service time, Q16.16
//  result   | m_valid m_ready m_response_time m_saturated | Q32.16 + clip flag
//  config   | psel penable pwrite paddr pwdata prdata pready | c, u
//
// One server: the result comes from a single 48-step divide.
// c servers: the serial divider is shared by the Erlang B recurrence,
// the Erlang C step and the final term.
// Reset is synchronous, active low; it gives cpu_count = 1, utilisation = 0.
// A stalled result waits in the output register; the next input transfer
// is taken once the result has moved there.
`timescale 1ns / 1ps
module erlang_c_response_time (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_service_time,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [47:0] m_response_time,
    output logic        m_saturated,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam logic REG_CPU  = 1'b0;
    localparam logic REG_UTIL = 1'b1;

    logic [erct_pkg::CNT_W-1:0]  cpu_reg;
    logic [erct_pkg::UTIL_W-1:0] util_reg;
    logic                        m_valid_reg;
    logic [erct_pkg::RESP_W-1:0] resp_reg, dp_resp;
    logic                        sat_reg, dp_sat;
    logic                        out_load, out_free;
    erct_pkg::dp_cmd_t           cmd;
    erct_pkg::dp_stat_t          stat;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpu_reg  <= erct_pkg::CNT_W'(1);
            util_reg <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_CPU:  cpu_reg  <= pwdata[erct_pkg::CNT_W-1:0];
                REG_UTIL: util_reg <= pwdata[erct_pkg::UTIL_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_CPU:  prdata = 32'(cpu_reg);
            REG_UTIL: prdata = 32'(util_reg);
            default:  prdata = '0;
        endcase
    end

    erct_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .out_free (out_free),
        .out_load (out_load),
        .stat     (stat),
        .cmd      (cmd)
    );

    erct_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .cpu_count     (cpu_reg),
        .utilisation   (util_reg),
        .service_time  (s_service_time),
        .response_time (dp_resp),
        .saturated     (dp_sat)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            m_valid_reg <= 1'b0;
        else if (out_load)
            m_valid_reg <= 1'b1;
        else if (m_ready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            resp_reg <= dp_resp;
            sat_reg  <= dp_sat;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_response_time = resp_reg;
    assign m_saturated     = sat_reg;
endmodule

FILE: hdl/erct_div.sv
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module erct_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [erct_pkg::DEN_W-1:0]       den,
    input  logic [erct_pkg::DEN_W-1:0]       rem_init,
    input  logic [erct_pkg::WORD_W-1:0]      word,
    input  logic [erct_pkg::STEP_W-1:0]      steps,
    output logic [erct_pkg::WORD_W-1:0]      quot,
    output logic                             done
);
    logic [erct_pkg::DEN_W-1:0]  den_reg, rem_reg, rem_next;
    logic [erct_pkg::WORD_W-1:0] word_reg, q_reg;
    logic [erct_pkg::STEP_W-1:0] cnt_reg;
    logic                        busy_reg, done_reg;
    logic [erct_pkg::DEN_W:0]    sh;
    logic                        qbit;

    always_comb begin
        sh   = {rem_reg, word_reg[erct_pkg::WORD_W-1]};
        qbit = (sh >= {1'b0, den_reg});
        rem_next = qbit ? erct_pkg::DEN_W'(sh - {1'b0, den_reg})
                        : sh[erct_pkg::DEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == erct_pkg::STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg  <= den;
            rem_reg  <= rem_init;
            word_reg <= word;
            q_reg    <= '0;
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            word_reg <= {word_reg[erct_pkg::WORD_W-2:0], 1'b0};
            q_reg    <= {q_reg[erct_pkg::WORD_W-2:0], qbit};
        end
    end

    assign quot = q_reg;
    assign done = done_reg;
endmodule

FILE: hdl/erct_dp.sv
// Datapath: operand registers, shared multiplier, divider and result sum.
`timescale 1ns / 1ps
module erct_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  erct_pkg::dp_cmd_t                 cmd,
    output erct_pkg::dp_stat_t                stat,
    input  logic [erct_pkg::CNT_W-1:0]        cpu_count,
    input  logic [erct_pkg::UTIL_W-1:0]       utilisation,
    input  logic [erct_pkg::SVC_W-1:0]        service_time,
    output logic [erct_pkg::RESP_W-1:0]       response_time,
    output logic                              saturated
);
    localparam int TW = 2 * erct_pkg::MUL_W - erct_pkg::UTIL_W;

    logic [erct_pkg::SVC_W-1:0]  s_reg;
    logic [erct_pkg::CNT_W-1:0]  c_reg, k_reg, c_eff;
    logic [erct_pkg::UTIL_W-1:0] u_reg;
    logic [erct_pkg::LOAD_W-1:0] a_reg;
    logic [erct_pkg::PROB_W-1:0] b_reg, cp_reg, ob;
    logic [2*erct_pkg::MUL_W-1:0] prod_reg;
    logic [erct_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic [erct_pkg::RESP_W-1:0] res_reg;
    logic                        sat_reg;
    logic [erct_pkg::UTIL_W:0]   d;
    logic [TW-1:0]               t;
    logic [erct_pkg::DEN_W-1:0]  den, rem_init;
    logic [erct_pkg::WORD_W-1:0] word, quot;
    logic [erct_pkg::STEP_W-1:0] steps;
    logic [erct_pkg::PROB_W-1:0] den2;
    logic [erct_pkg::CNT_W+erct_pkg::UTIL_W:0] cd;
    logic [erct_pkg::WORD_W:0]   sum;
    logic                        div_done;

    always_comb begin
        if (cpu_count == '0)
            c_eff = erct_pkg::CNT_W'(1);
        else if (cpu_count > erct_pkg::CNT_W'(erct_pkg::MAX_SERVERS))
            c_eff = erct_pkg::CNT_W'(erct_pkg::MAX_SERVERS);
        else
            c_eff = cpu_count;
    end

    assign d  = (erct_pkg::UTIL_W+1)'(1 << erct_pkg::UTIL_W) - {1'b0, u_reg};
    assign ob = erct_pkg::PROB_ONE - b_reg;
    assign t  = prod_reg[2*erct_pkg::MUL_W-1:erct_pkg::UTIL_W];
    assign cd = c_reg * d;
    // 1 - u*(1-B), the product truncated back to the probability format
    assign den2 = erct_pkg::PROB_ONE
                - erct_pkg::PROB_W'(prod_reg >> erct_pkg::UTIL_W);

    always_comb begin
        case (cmd.mul_sel)
            erct_pkg::MS_AB: begin
                mul_a = erct_pkg::MUL_W'(a_reg);
                mul_b = erct_pkg::MUL_W'(b_reg);
            end
            erct_pkg::MS_UOB: begin
                mul_a = erct_pkg::MUL_W'(u_reg);
                mul_b = erct_pkg::MUL_W'(ob);
            end
            default: begin
                mul_a = erct_pkg::MUL_W'(cp_reg);
                mul_b = s_reg;
            end
        endcase
    end

    always_comb begin
        case (cmd.div_sel)
            erct_pkg::DS_ONE: begin
                den      = erct_pkg::DEN_W'(d);
                rem_init = '0;
                word     = {s_reg, {(erct_pkg::WORD_W-erct_pkg::SVC_W){1'b0}}};
                steps    = erct_pkg::STEP_W'(erct_pkg::SVC_W + erct_pkg::UTIL_W);
            end
            erct_pkg::DS_B: begin
                den      = erct_pkg::DEN_W'({k_reg, {erct_pkg::PROB_FRAC_BITS{1'b0}}})
                         + erct_pkg::DEN_W'(t);
                rem_init = erct_pkg::DEN_W'(t >> 1);
                word     = {t[0], {(erct_pkg::WORD_W-1){1'b0}}};
                steps    = erct_pkg::STEP_W'(erct_pkg::PROB_FRAC_BITS + 1);
            end
            erct_pkg::DS_C: begin
                den      = erct_pkg::DEN_W'(den2);
                rem_init = erct_pkg::DEN_W'(b_reg >> 1);
                word     = {b_reg[0], {(erct_pkg::WORD_W-1){1'b0}}};
                steps    = erct_pkg::STEP_W'(erct_pkg::PROB_FRAC_BITS + 1);
            end
            default: begin
                den      = erct_pkg::DEN_W'(cd) << (erct_pkg::PROB_FRAC_BITS
                                                    - erct_pkg::UTIL_W);
                rem_init = '0;
                word     = {prod_reg[2*erct_pkg::MUL_W-2:0], 1'b0};
                steps    = erct_pkg::STEP_W'(2 * erct_pkg::MUL_W - 1);
            end
        endcase
    end

    erct_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_go),
        .den      (den),
        .rem_init (rem_init),
        .word     (word),
        .steps    (steps),
        .quot     (quot),
        .done     (div_done)
    );

    assign sum = {1'b0, quot} + (cmd.res_fin ? (erct_pkg::WORD_W+1)'(s_reg)
                                             : '0);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            s_reg <= service_time;
            c_reg <= c_eff;
            u_reg <= utilisation;
            a_reg <= c_eff * utilisation;
            b_reg <= erct_pkg::PROB_ONE;
            k_reg <= erct_pkg::CNT_W'(1);
        end
        if (cmd.mul_go)
            prod_reg <= mul_a * mul_b;
        if (cmd.b_upd) begin
            b_reg <= quot[erct_pkg::PROB_W-1:0];
            k_reg <= k_reg + 1'b1;
        end
        if (cmd.c_upd)
            cp_reg <= quot[erct_pkg::PROB_W-1:0];
        if (cmd.res_upd) begin
            // clip to the largest Q32.16 value
            if (sum[erct_pkg::WORD_W:erct_pkg::RESP_W] != '0) begin
                res_reg <= '1;
                sat_reg <= 1'b1;
            end else begin
                res_reg <= sum[erct_pkg::RESP_W-1:0];
                sat_reg <= 1'b0;
            end
        end
    end

    assign stat.div_done  = div_done;
    assign stat.single    = (c_reg == erct_pkg::CNT_W'(1));
    assign stat.k_last    = (k_reg == c_reg);
    assign response_time  = res_reg;
    assign saturated      = sat_reg;
endmodule

FILE: hdl/erct_ctrl.sv
// Controller: one-server divide, or recurrence, Erlang C step and final term.
`timescale 1ns / 1ps
module erct_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 out_free,
    output logic                 out_load,
    input  erct_pkg::dp_stat_t   stat,
    output erct_pkg::dp_cmd_t    cmd
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_DISPATCH, ST_ONE_WAIT, ST_B_MUL, ST_B_DIV, ST_B_WAIT,
        ST_C_MUL, ST_C_DIV, ST_C_WAIT, ST_F_MUL, ST_F_DIV, ST_F_WAIT, ST_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = erct_pkg::MS_AB;
        cmd.div_sel = erct_pkg::DS_ONE;
        in_ready    = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (stat.single) begin
                    cmd.div_go  = 1'b1;
                    cmd.div_sel = erct_pkg::DS_ONE;
                    state_next  = ST_ONE_WAIT;
                end else begin
                    state_next = ST_B_MUL;
                end
            end
            ST_ONE_WAIT: begin
                if (stat.div_done) begin
                    cmd.res_upd = 1'b1;
                    state_next  = ST_OUT;
                end
            end
            ST_B_MUL: begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = erct_pkg::MS_AB;
                state_next  = ST_B_DIV;
            end
            ST_B_DIV: begin
                cmd.div_go  = 1'b1;
                cmd.div_sel = erct_pkg::DS_B;
                state_next  = ST_B_WAIT;
            end
            ST_B_WAIT: begin
                if (stat.div_done) begin
                    cmd.b_upd  = 1'b1;
                    state_next = stat.k_last ? ST_C_MUL : ST_B_MUL;
                end
            end
            ST_C_MUL: begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = erct_pkg::MS_UOB;
                state_next  = ST_C_DIV;
            end
            ST_C_DIV: begin
                cmd.div_go  = 1'b1;
                cmd.div_sel = erct_pkg::DS_C;
                state_next  = ST_C_WAIT;
            end
            ST_C_WAIT: begin
                if (stat.div_done) begin
                    cmd.c_upd  = 1'b1;
                    state_next = ST_F_MUL;
                end
            end
            ST_F_MUL: begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = erct_pkg::MS_CS;
                state_next  = ST_F_DIV;
            end
            ST_F_DIV: begin
                cmd.div_go  = 1'b1;
                cmd.div_sel = erct_pkg::DS_F;
                state_next  = ST_F_WAIT;
            end
            ST_F_WAIT: begin
                if (stat.div_done) begin
                    cmd.res_upd = 1'b1;
                    cmd.res_fin = 1'b1;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT: begin
                // hold the result until the output register frees
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end
endmodule

FILE: tb/erct_response_checker.sv
// Checker for the M/M/c response time block: predicts results and compares transfers.
`timescale 1ns / 1ps
module erct_response_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_service_time,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [47:0] m_response_time,
    input  logic        m_saturated,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          pending,
    output int          fail_count
);

    localparam logic [2:0] ADDR_CPU_COUNT   = 3'd0;
    localparam logic [2:0] ADDR_UTILISATION = 3'd4;
    localparam logic [63:0] RESP_LIMIT      = (64'd1 << erct_pkg::RESP_W) - 64'd1;

    typedef struct packed {
        logic [47:0] response_time;
        logic        saturated;
    } response_t;

    logic [erct_pkg::CNT_W-1:0]  servers_q;
    logic [erct_pkg::UTIL_W-1:0] load_q;
    response_t                   expected_responses[$];

    // Response time for one service time under the current server count and load.
    function automatic response_t mmc_response(logic [erct_pkg::CNT_W-1:0] cnt,
                                               logic [erct_pkg::UTIL_W-1:0] util,
                                               logic [erct_pkg::SVC_W-1:0] svc);
        logic [63:0]  c, u, s, d, a, b, t, ob, den, cp, res;
        logic [63:0]  one;
        logic [127:0] q;
        response_t    r;
        one = 64'd1 << erct_pkg::PROB_FRAC_BITS;
        c = 64'(cnt);
        u = 64'(util);
        s = 64'(svc);
        if (c == 0) c = 1;
        if (c > erct_pkg::MAX_SERVERS) c = erct_pkg::MAX_SERVERS;
        d = 64'd65536 - u;
        if (c == 1) begin
            res = (s << 16) / d;
        end else begin
            a = c * u;
            b = one;
            for (logic [63:0] k = 1; k <= c; k++) begin
                t = (a * b) >> 16;
                q = (128'(t) << erct_pkg::PROB_FRAC_BITS)
                  / 128'((k << erct_pkg::PROB_FRAC_BITS) + t);
                b = q[63:0];
            end
            ob = one - b;
            den = one - ((u * ob) >> 16);
            q = (128'(b) << erct_pkg::PROB_FRAC_BITS) / 128'(den);
            cp = q[63:0];
            q = (128'(cp) * 128'(s))
              / 128'((c * d) << (erct_pkg::PROB_FRAC_BITS - 16));
            res = s + q[63:0];
        end
        r.saturated = 1'b0;
        if (res > RESP_LIMIT) begin
            res = RESP_LIMIT;
            r.saturated = 1'b1;
        end
        r.response_time = res[47:0];
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        response_t want;
        if (!aresetn) begin
            servers_q  <= erct_pkg::CNT_W'(1);
            load_q     <= '0;
            fail_count <= 0;
            pending    <= 0;
            expected_responses.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr)
                    ADDR_CPU_COUNT:   servers_q <= pwdata[erct_pkg::CNT_W-1:0];
                    ADDR_UTILISATION: load_q    <= pwdata[erct_pkg::UTIL_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_responses.size() == 0) begin
                    $error("unexpected result transfer: response_time %0d", m_response_time);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_responses.pop_front();
                    if (want.response_time !== m_response_time ||
                        want.saturated !== m_saturated) begin
                        if (want.response_time !== m_response_time)
                            $error("response_time: expected %0d, got %0d",
                                   want.response_time, m_response_time);
                        if (want.saturated !== m_saturated)
                            $error("saturated: expected %0d, got %0d",
                                   want.saturated, m_saturated);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_responses.push_back(mmc_response(servers_q, load_q, s_service_time));
            pending <= expected_responses.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
// Testbench top: clock, reset, stimulus and verdict for the response time block.
`timescale 1ns / 1ps
module tb_top;

    localparam logic [2:0] ADDR_CPU_COUNT   = 3'd0;
    localparam logic [2:0] ADDR_UTILISATION = 3'd4;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_service_time = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [47:0] m_response_time;
    logic        m_saturated;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int pending;
    int fail_count;
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    bit hold_req   = 1'b0;

    always #6 aclk = ~aclk;

    erlang_c_response_time dut (.*);

    erct_response_checker checker_i (.*);

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (3000) @(posedge aclk);
                hold_req = 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Stop offering, drain, then set the server count and load.
    task automatic set_queue(input logic [31:0] cnt, input logic [31:0] util);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        reg_write(ADDR_CPU_COUNT, cnt);
        reg_write(ADDR_UTILISATION, util);
    endtask

    task automatic send_service(input logic [31:0] svc);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_service_time <= svc;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic logic [31:0] random_service();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 255);
            1:       return 32'd1 << $urandom_range(0, 31);
            2:       return ~(32'd1 << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] random_load();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'd65535;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    initial begin
        logic [31:0] cnt;
        int          n;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes under each server count special case
        set_queue(1, 0);
        send_service(32'd0);
        send_service(32'hFFFF_FFFF);
        send_service(32'd1);
        send_service(32'h0001_0000);
        set_queue(1, 65535);
        send_service(32'd0);
        send_service(32'hFFFF_FFFF);
        send_service(32'h8000_0000);
        send_service(32'h5555_5555);
        set_queue(0, 32768);
        send_service(32'hAAAA_AAAA);
        send_service(32'h0000_FFFF);
        set_queue(2, 0);
        send_service(32'hFFFF_FFFF);
        send_service(32'd7);
        set_queue(64, 65535);
        send_service(32'hFFFF_FFFF);
        send_service(32'd1);
        set_queue(100, 1);
        send_service(32'h1234_5678);
        set_queue(127, 60000);
        send_service(32'hFFFF_FFFF);
        set_queue(2, 65535);
        send_service(32'hFFFF_FFFF);
        send_service(32'hFFFF_0000);

        // random phases
        for (int ph = 0; ph < 20; ph++) begin
            if (ph >= 17) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            case ($urandom_range(0, 9))
                0:       cnt = $urandom_range(64, 127);
                1:       cnt = 0;
                default: cnt = $urandom_range(1, 8);
            endcase
            set_queue(cnt, random_load());
            n = (cnt > 16) ? 3 : 14;
            if (ph == 3) begin
                // fill the block while results are held back
                set_queue(2, random_load());
                hold_req = 1'b1;
                n = 14;
            end
            for (int i = 0; i < n; i++) send_service(random_service());
            s_valid <= 1'b0;
            @(posedge aclk);
        end

        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #30ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
